[hdl/cpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the checksummed packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int MAX_PAYLOAD = 32;
    // address bits within one payload bank
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    // holds 0 .. MAX_PAYLOAD
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int NUM_BANKS   = 2;
    localparam int RAM_AW      = PAY_AW + 1;
    localparam int RAM_DEPTH   = NUM_BANKS * (2 ** PAY_AW);

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 5;
    localparam int FLEN_W      = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_TRL1  = 3'd4,
        PH_TRL2  = 3'd5
    } t_phase;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_RUN  = 1'b1
    } t_back_state;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] len;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic              re;
        logic [RAM_AW-1:0] addr;
    } t_rd;

endpackage

[hdl/checksummed_packet_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_packet_deframer_core
// Receives framed bytes, checks a Fletcher-style trailer and streams the
// payload of each passing frame.
// ----------------------------------------------------------------------------
//  channel   valid         stall         payload
//  rx        i_rx_valid    o_rx_stall    i_rx_byte
//  out       o_out_valid   i_out_stall   o_payload_byte, o_byte_position,
//                                        o_frame_length, o_last
//  cfg       i_cfg_we      -             i_cfg_index, i_cfg_data
//
// One rx byte is taken per cycle while o_rx_stall is low. Payload is stored
// in one of two RAM banks; a payload byte stalls only while both banks still
// hold frames awaiting readout. A passed frame is queued in the descriptor
// FIFO, then read out via the RAM read port, one item a cycle unless stalled.
// Reset is synchronous and clears control state only; no clearing pass.
// ----------------------------------------------------------------------------
module checksummed_packet_deframer_core
    import cpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_rx_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [POS_W-1:0]     o_byte_position,
    output logic [FLEN_W-1:0]    o_frame_length,
    output logic                 o_last
);

    t_wr               w_wr;
    t_rd               w_rd;
    t_push             w_push;
    t_release          w_release;
    t_desc             w_head;
    logic              w_empty;
    logic              w_pop;
    logic [BYTE_W-1:0] w_rdata;

    cpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_stall  (o_rx_stall),
        .o_wr        (w_wr),
        .o_push      (w_push),
        .i_release   (w_release)
    );

    cpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd.re),
        .i_raddr (w_rd.addr),
        .o_rdata (w_rdata)
    );

    cpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    cpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fifo_empty    (w_empty),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_rd            (w_rd),
        .i_rdata         (w_rdata),
        .o_release       (w_release),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_byte_position (o_byte_position),
        .o_frame_length  (o_frame_length),
        .o_last          (o_last)
    );

endmodule

[hdl/cpd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/cpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_front
// Frame parser: sync hunt, length check, payload store and Fletcher check.
// ----------------------------------------------------------------------------
module cpd_front
    import cpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_rx_stall,
    output t_wr                  o_wr,
    output t_push                o_push,
    input  t_release             i_release
);

    t_phase                r_phase, n_phase;
    logic [BYTE_W-1:0]     r_sync1, r_sync2;
    logic [CNT_W-1:0]      r_exp_len, n_exp_len;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [BYTE_W-1:0]     r_sum, n_sum;
    logic [BYTE_W-1:0]     r_sos, n_sos;
    logic                  r_wr_bank;
    logic [NUM_BANKS-1:0]  r_busy;

    logic                  w_acc;
    logic                  w_len_ok;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic [BYTE_W-1:0]     w_sum_add;

    assign w_acc     = i_rx_valid && !o_rx_stall;
    assign w_len_ok  = (i_rx_byte != '0) && (i_rx_byte <= BYTE_W'(MAX_PAYLOAD));
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    assign w_sum_add = r_sum + i_rx_byte;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            unique case (r_phase)
                PH_HUNT1: n_phase = (i_rx_byte == r_sync1) ? PH_HUNT2 : PH_HUNT1;
                PH_HUNT2: n_phase = (i_rx_byte == r_sync2) ? PH_LEN : PH_HUNT1;
                PH_LEN:   n_phase = w_len_ok ? PH_DATA : PH_HUNT1;
                PH_DATA:  n_phase = (w_cnt_inc >= r_exp_len) ? PH_TRL1 : PH_DATA;
                PH_TRL1:  n_phase = (i_rx_byte == r_sum) ? PH_TRL2 : PH_HUNT1;
                PH_TRL2:  n_phase = PH_HUNT1;
                default:  n_phase = PH_HUNT1;
            endcase
        end
    end

    // datapath and outputs
    always_comb begin
        n_exp_len = r_exp_len;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_sos     = r_sos;
        if (w_acc && r_phase == PH_LEN && w_len_ok) begin
            n_exp_len = CNT_W'(i_rx_byte);
            n_cnt     = '0;
            n_sum     = i_rx_byte;
            n_sos     = i_rx_byte;
        end else if (w_acc && r_phase == PH_DATA) begin
            n_cnt = w_cnt_inc;
            n_sum = w_sum_add;
            n_sos = r_sos + w_sum_add;
        end

        // the bank being filled must not still be waiting for readout
        o_rx_stall = (r_phase == PH_DATA) && r_busy[r_wr_bank];

        o_wr.we   = w_acc && (r_phase == PH_DATA);
        o_wr.addr = {r_wr_bank, r_cnt[PAY_AW-1:0]};
        o_wr.data = i_rx_byte;

        o_push.valid     = w_acc && (r_phase == PH_TRL2) && (i_rx_byte == r_sos);
        o_push.desc.bank = r_wr_bank;
        o_push.desc.len  = r_exp_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_sync1   <= SYNC_FIRST_RST;
            r_sync2   <= SYNC_SECOND_RST;
            r_exp_len <= '0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_sos     <= '0;
            r_wr_bank <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_cnt     <= n_cnt;
            r_sum     <= n_sum;
            r_sos     <= n_sos;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SYNC_FIRST:  r_sync1 <= i_cfg_data;
                    CFG_SYNC_SECOND: r_sync2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_release.valid) begin
                r_busy[i_release.bank] <= 1'b0;
            end
            if (o_push.valid) begin
                r_busy[r_wr_bank] <= 1'b1;
                r_wr_bank         <= !r_wr_bank;
            end
        end
    end

`ifndef ASSERT_OFF
    // only a bank that holds a passed frame can be released
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release.valid |-> r_busy[i_release.bank])
        else $error("release of a bank that is not busy");
`endif

endmodule

[hdl/cpd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_fifo
// Two-entry queue of passed-frame descriptors between parser and readout.
// ----------------------------------------------------------------------------
module cpd_fifo
    import cpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_head
);

    t_desc      r_mem [NUM_BANKS];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(i_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_cnt != 2'd2) || i_pop)
        else $error("descriptor queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("descriptor queue underflow");
`endif

endmodule

[hdl/cpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_back
// Payload readout: streams a passed frame, one item a cycle unless stalled.
// ----------------------------------------------------------------------------
module cpd_back
    import cpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fifo_empty,
    input  t_desc             i_head,
    output logic              o_pop,
    output t_rd               o_rd,
    input  logic [BYTE_W-1:0] i_rdata,
    output t_release          o_release,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [POS_W-1:0]  o_byte_position,
    output logic [FLEN_W-1:0] o_frame_length,
    output logic              o_last
);

    t_back_state       r_state, n_state;
    logic              r_bank;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_pos;
    logic [FLEN_W-1:0] r_flen;
    logic              r_last;

    logic              w_adv;
    logic              w_issue;
    logic              w_last_issue;
    logic [CNT_W-1:0]  w_idx_inc;

    // output stage free or being emptied this cycle
    assign w_adv        = !r_out_valid || !i_out_stall;
    assign w_idx_inc    = r_idx + CNT_W'(1);
    assign w_last_issue = (w_idx_inc == r_len);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_fifo_empty) n_state = B_RUN;
            B_RUN:   if (w_adv && w_last_issue) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop             = (r_state == B_IDLE) && !i_fifo_empty;
        w_issue           = (r_state == B_RUN) && w_adv;
        o_rd.re           = w_issue;
        o_rd.addr         = {r_bank, r_idx[PAY_AW-1:0]};
        o_release.valid   = w_issue && w_last_issue;
        o_release.bank    = r_bank;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank <= i_head.bank;
            r_len  <= i_head.len;
            r_idx  <= '0;
        end else if (w_issue) begin
            r_idx <= w_idx_inc;
        end
        if (w_issue) begin
            r_pos  <= POS_W'(r_idx);
            r_flen <= FLEN_W'(r_len);
            r_last <= w_last_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_out_valid <= w_issue;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = i_rdata;
    assign o_byte_position = r_pos;
    assign o_frame_length  = r_flen;
    assign o_last          = r_last;

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN) |-> (r_idx < r_len))
        else $error("readout index past frame length");
`endif

endmodule
